@@ hdl/gsm_pkg.sv @@
package gsm_pkg;

  localparam int WORD_W   = 32;
  localparam int TOL_W    = 31;
  localparam int TAU_BITS = 16;
  // (3 - sqrt 5) / 2 in Q0.16
  localparam logic [TAU_BITS-1:0] TAU_Q = 16'd25032;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

  typedef enum logic {
    OP_START = 1'b0,
    OP_REPLY = 1'b1
  } op_kind_t;

  // word_a carries the lower bound on a start and the function value on a reply
  typedef struct packed {
    op_kind_t                 kind;
    logic signed [WORD_W-1:0] word_a;
    logic signed [WORD_W-1:0] word_b;
  } op_t;

endpackage

@@ hdl/gsm_front.sv @@
module gsm_front import gsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic signed [WORD_W-1:0] in_lower_bound,
  input  logic signed [WORD_W-1:0] in_upper_bound,
  input  logic signed [WORD_W-1:0] in_func_value,
  output logic                     fr_valid,
  input  logic                     fr_ready,
  output op_t                      fr_op
);

  logic fr_valid_r;
  logic fr_valid_nxt;
  op_t  fr_op_r;
  op_t  fr_op_nxt;

  assign in_ready = !fr_valid_r || fr_ready;
  assign fr_valid = fr_valid_r;
  assign fr_op    = fr_op_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_op_nxt    = fr_op_r;
    if (fr_valid_r && fr_ready) begin
      fr_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      fr_valid_nxt = 1'b1;
      if (in_mode == 1'b0) begin
        fr_op_nxt.kind   = OP_START;
        fr_op_nxt.word_a = in_lower_bound;
        fr_op_nxt.word_b = in_upper_bound;
      end else begin
        fr_op_nxt.kind   = OP_REPLY;
        fr_op_nxt.word_a = in_func_value;
        fr_op_nxt.word_b = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_op_r <= fr_op_nxt;
  end

endmodule

@@ hdl/gsm_queue.sv @@
module gsm_queue import gsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop,
  output op_t  pop_op
);

  op_t        mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ hdl/gsm_back.sv @@
module gsm_back import gsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [TOL_W-1:0]         cfg_wr_data,
  input  logic                     q_valid,
  input  op_t                      q_op,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_finished,
  output logic signed [WORD_W-1:0] out_position
);

  localparam int PW = WORD_W + TAU_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (TAU_BITS - 1);

  typedef enum logic [2:0] {
    P_IDLE,
    P_LEFT,
    P_RIGHT,
    P_PAIR,
    P_IR_LAST,
    P_IL_LAST
  } pend_t;

  typedef enum logic [1:0] {
    PH_EXEC,
    PH_DIFF,
    PH_MUL,
    PH_PLACE
  } phase_t;

  typedef enum logic [1:0] {
    PL_BOTH,
    PL_LEFT,
    PL_RIGHT
  } place_t;

  logic [TOL_W-1:0]         tol_r;
  logic signed [WORD_W-1:0] lp_r, ilp_r, irp_r, rp_r;
  logic signed [WORD_W-1:0] lv_r, ilv_r, irv_r, rv_r;
  logic signed [WORD_W-1:0] lp_nxt, ilp_nxt, irp_nxt, rp_nxt;
  logic signed [WORD_W-1:0] lv_nxt, ilv_nxt, irv_nxt, rv_nxt;
  pend_t                    pend_r, pend_nxt;
  phase_t                   ph_r, ph_nxt;
  place_t                   plk_r, plk_nxt;
  logic [WORD_W-1:0]        mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [WORD_W-1:0]        step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_fin_r, out_fin_nxt;
  logic signed [WORD_W-1:0] out_pos_r, out_pos_nxt;

  logic                     out_free;
  logic                     out_load;
  logic signed [WORD_W:0]   d_cur;
  logic signed [WORD_W:0]   tol_ext;
  logic                     within_tol;
  logic signed [WORD_W:0]   sum_cur;
  logic signed [WORD_W-1:0] dec_a, dec_b, f;
  logic [PW-1:0]            prod;
  logic signed [WORD_W:0]   s_ext;
  logic signed [WORD_W:0]   il_new, ir_new;

  assign out_valid    = out_valid_r;
  assign out_finished = out_fin_r;
  assign out_position = out_pos_r;
  assign out_free     = !out_valid_r || out_ready;

  assign f       = q_op.word_a;
  assign d_cur   = {rp_r[WORD_W-1], rp_r} - {lp_r[WORD_W-1], lp_r};
  assign sum_cur = {rp_r[WORD_W-1], rp_r} + {lp_r[WORD_W-1], lp_r};
  assign tol_ext = {2'b00, tol_r};
  // width test without an abs: two compares side by side
  assign within_tol = d_cur[WORD_W] ? (d_cur >= -tol_ext) : (d_cur <= tol_ext);
  assign dec_a   = (pend_r == P_IL_LAST) ? f : ilv_r;
  assign dec_b   = (pend_r == P_IR_LAST) ? f : irv_r;

  // rounded magnitude step, half away from zero
  assign prod   = {{TAU_BITS{1'b0}}, mag_r} * {{WORD_W{1'b0}}, TAU_Q} + HALF;
  assign s_ext  = {1'b0, step_r};
  assign il_new = neg_r ? ({lp_r[WORD_W-1], lp_r} - s_ext) : ({lp_r[WORD_W-1], lp_r} + s_ext);
  assign ir_new = neg_r ? ({rp_r[WORD_W-1], rp_r} + s_ext) : ({rp_r[WORD_W-1], rp_r} - s_ext);

  always_comb begin
    lp_nxt = lp_r; ilp_nxt = ilp_r; irp_nxt = irp_r; rp_nxt = rp_r;
    lv_nxt = lv_r; ilv_nxt = ilv_r; irv_nxt = irv_r; rv_nxt = rv_r;
    pend_nxt    = pend_r;
    ph_nxt      = ph_r;
    plk_nxt     = plk_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    step_nxt    = step_r;
    q_pop       = 1'b0;
    out_load    = 1'b0;
    out_fin_nxt = out_fin_r;
    out_pos_nxt = out_pos_r;

    case (ph_r)
      PH_EXEC: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_op.kind == OP_START) begin
            lp_nxt      = q_op.word_a;
            rp_nxt      = q_op.word_b;
            pend_nxt    = P_LEFT;
            out_load    = 1'b1;
            out_fin_nxt = 1'b0;
            out_pos_nxt = q_op.word_a;
          end else begin
            case (pend_r)
              P_LEFT: begin
                lv_nxt      = f;
                pend_nxt    = P_RIGHT;
                out_load    = 1'b1;
                out_fin_nxt = 1'b0;
                out_pos_nxt = rp_r;
              end
              P_RIGHT: begin
                rv_nxt   = f;
                pend_nxt = P_PAIR;
                plk_nxt  = PL_BOTH;
                ph_nxt   = PH_DIFF;
              end
              P_PAIR: begin
                ilv_nxt     = f;
                pend_nxt    = P_IR_LAST;
                out_load    = 1'b1;
                out_fin_nxt = 1'b0;
                out_pos_nxt = irp_r;
              end
              P_IR_LAST, P_IL_LAST: begin
                if (pend_r == P_IR_LAST) begin
                  irv_nxt = f;
                end else begin
                  ilv_nxt = f;
                end
                if (within_tol) begin
                  pend_nxt    = P_IDLE;
                  out_load    = 1'b1;
                  out_fin_nxt = 1'b1;
                  out_pos_nxt = sum_cur[WORD_W:1];
                end else begin
                  ph_nxt = PH_DIFF;
                  if (dec_a < dec_b) begin
                    if (lv_r <= dec_a) begin
                      rp_nxt   = ilp_r;
                      rv_nxt   = dec_a;
                      plk_nxt  = PL_BOTH;
                      pend_nxt = P_PAIR;
                    end else begin
                      rp_nxt   = irp_r;
                      rv_nxt   = dec_b;
                      irp_nxt  = ilp_r;
                      irv_nxt  = dec_a;
                      plk_nxt  = PL_LEFT;
                      pend_nxt = P_IL_LAST;
                    end
                  end else if (dec_a > dec_b) begin
                    if (dec_b >= rv_r) begin
                      lp_nxt   = irp_r;
                      lv_nxt   = dec_b;
                      plk_nxt  = PL_BOTH;
                      pend_nxt = P_PAIR;
                    end else begin
                      lp_nxt   = ilp_r;
                      lv_nxt   = dec_a;
                      ilp_nxt  = irp_r;
                      ilv_nxt  = dec_b;
                      plk_nxt  = PL_RIGHT;
                      pend_nxt = P_IR_LAST;
                    end
                  end else begin
                    // equal inner values: bracket becomes the inner pair
                    lp_nxt   = ilp_r;
                    lv_nxt   = dec_a;
                    rp_nxt   = irp_r;
                    rv_nxt   = dec_b;
                    plk_nxt  = PL_BOTH;
                    pend_nxt = P_PAIR;
                  end
                end
              end
              default: begin
                // reply with no probe outstanding is dropped
              end
            endcase
          end
        end
      end
      PH_DIFF: begin
        neg_nxt = d_cur[WORD_W];
        mag_nxt = d_cur[WORD_W] ? WORD_W'(-d_cur) : d_cur[WORD_W-1:0];
        ph_nxt  = PH_MUL;
      end
      PH_MUL: begin
        step_nxt = prod[PW-1:TAU_BITS];
        ph_nxt   = PH_PLACE;
      end
      PH_PLACE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_fin_nxt = 1'b0;
          ph_nxt      = PH_EXEC;
          case (plk_r)
            PL_BOTH: begin
              ilp_nxt     = il_new[WORD_W-1:0];
              irp_nxt     = ir_new[WORD_W-1:0];
              out_pos_nxt = il_new[WORD_W-1:0];
            end
            PL_LEFT: begin
              ilp_nxt     = il_new[WORD_W-1:0];
              out_pos_nxt = il_new[WORD_W-1:0];
            end
            default: begin
              irp_nxt     = ir_new[WORD_W-1:0];
              out_pos_nxt = ir_new[WORD_W-1:0];
            end
          endcase
        end
      end
      default: begin
        ph_nxt = PH_EXEC;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      lp_r        <= '0;
      ilp_r       <= '0;
      irp_r       <= '0;
      rp_r        <= '0;
      lv_r        <= '0;
      ilv_r       <= '0;
      irv_r       <= '0;
      rv_r        <= '0;
      pend_r      <= P_IDLE;
      ph_r        <= PH_EXEC;
      plk_r       <= PL_BOTH;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      lp_r        <= lp_nxt;
      ilp_r       <= ilp_nxt;
      irp_r       <= irp_nxt;
      rp_r        <= rp_nxt;
      lv_r        <= lv_nxt;
      ilv_r       <= ilv_nxt;
      irv_r       <= irv_nxt;
      rv_r        <= rv_nxt;
      pend_r      <= pend_nxt;
      ph_r        <= ph_nxt;
      plk_r       <= plk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    step_r    <= step_nxt;
    out_fin_r <= out_fin_nxt;
    out_pos_r <= out_pos_nxt;
  end

  a_pop_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_EXEC) |-> !q_pop)
    else $error("queue popped while a placement is in flight");

  a_place_has_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_PLACE) |->
      (pend_r == P_PAIR || pend_r == P_IL_LAST || pend_r == P_IR_LAST))
    else $error("placement without an inner probe outstanding");

  a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_fin_nxt) |=> (pend_r == P_IDLE))
    else $error("final result left a probe outstanding");

  a_no_load_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_pos_r))
    else $error("result overwritten while waiting");

endmodule

@@ hdl/golden_section_minimizer_unit.sv @@
// channel  | handshake            | payload
// in_      | in_valid / in_ready  | in_mode, in_lower_bound, in_upper_bound, in_func_value
// out_     | out_valid/ out_ready | out_finished, out_position
// cfg_     | cfg_wr_en            | cfg_wr_data (tolerance)
//
// a start, a left value reply, the first inner reply and a finishing reply give
// their result in the cycle after leaving the queue
// the right value reply and a narrowing reply go through the back end in steps:
// pop, difference, one 32x16 multiply for the golden step, then the point adds
// front register and two-entry queue keep taking transfers while the back end waits
// rst_n is synchronous; tolerance resets to 66, all points and values to zero
module golden_section_minimizer_unit import gsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [TOL_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic signed [WORD_W-1:0] in_lower_bound,
  input  logic signed [WORD_W-1:0] in_upper_bound,
  input  logic signed [WORD_W-1:0] in_func_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_finished,
  output logic signed [WORD_W-1:0] out_position
);

  logic fr_valid;
  logic fr_ready;
  op_t  fr_op;
  logic q_valid;
  logic q_pop;
  op_t  q_op;

  gsm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_lower_bound (in_lower_bound),
    .in_upper_bound (in_upper_bound),
    .in_func_value  (in_func_value),
    .fr_valid       (fr_valid),
    .fr_ready       (fr_ready),
    .fr_op          (fr_op)
  );

  gsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_op    (fr_op),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_op     (q_op)
  );

  gsm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_finished (out_finished),
    .out_position (out_position)
  );

endmodule

@@ tb/search_result_checker.sv @@
module search_result_checker import gsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [TOL_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_mode,
  input  logic signed [WORD_W-1:0] in_lower_bound,
  input  logic signed [WORD_W-1:0] in_upper_bound,
  input  logic signed [WORD_W-1:0] in_func_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_finished,
  input  logic signed [WORD_W-1:0] out_position,
  output int                       results_owed,
  output int                       answered_items,
  output int                       mismatches
);

  typedef enum logic [2:0] {
    AWAIT_NONE,
    AWAIT_LEFT,
    AWAIT_RIGHT,
    AWAIT_INNER_PAIR,
    AWAIT_INNER_RIGHT,
    AWAIT_INNER_LEFT
  } await_t;

  typedef struct packed {
    logic                     finished;
    logic signed [WORD_W-1:0] position;
  } search_out_t;

  longint          left_pt, inl_pt, inr_pt, right_pt;
  longint          left_val, inl_val, inr_val, right_val;
  longint unsigned tolerance;
  await_t          awaiting;
  search_out_t     owed_q[$];
  int              answered;
  int              failures;

  function automatic search_out_t probe_at(input logic done, input longint pt);
    search_out_t r;
    r.finished = done;
    r.position = pt[WORD_W-1:0];
    return r;
  endfunction

  // tau times the signed width, rounded half away from zero on the magnitude
  function automatic longint golden_step();
    longint          diff;
    longint unsigned mag, s;
    diff = right_pt - left_pt;
    mag = (diff < 0) ? -diff : diff;
    s = (mag * TAU_Q + (64'd1 << (TAU_BITS - 1))) >> TAU_BITS;
    return (diff < 0) ? -longint'(s) : longint'(s);
  endfunction

  function automatic search_out_t place_inner_pair();
    longint s;
    s = golden_step();
    inl_pt = left_pt + s;
    inr_pt = right_pt - s;
    awaiting = AWAIT_INNER_PAIR;
    return probe_at(1'b0, inl_pt);
  endfunction

  function automatic search_out_t narrow_bracket();
    longint          diff;
    longint unsigned width;
    diff = right_pt - left_pt;
    width = (diff < 0) ? -diff : diff;
    if (width <= tolerance) begin
      awaiting = AWAIT_NONE;
      return probe_at(1'b1, (left_pt + right_pt) >>> 1);
    end
    if (inl_val < inr_val) begin
      if (left_val <= inl_val) begin
        right_pt = inl_pt;
        right_val = inl_val;
        return place_inner_pair();
      end
      right_pt = inr_pt;
      right_val = inr_val;
      inr_pt = inl_pt;
      inr_val = inl_val;
      inl_pt = left_pt + golden_step();
      awaiting = AWAIT_INNER_LEFT;
      return probe_at(1'b0, inl_pt);
    end
    if (inl_val > inr_val) begin
      if (inr_val >= right_val) begin
        left_pt = inr_pt;
        left_val = inr_val;
        return place_inner_pair();
      end
      left_pt = inl_pt;
      left_val = inl_val;
      inl_pt = inr_pt;
      inl_val = inr_val;
      inr_pt = right_pt - golden_step();
      awaiting = AWAIT_INNER_RIGHT;
      return probe_at(1'b0, inr_pt);
    end
    // equal inner values: keep only the middle part
    left_pt = inl_pt;
    left_val = inl_val;
    right_pt = inr_pt;
    right_val = inr_val;
    return place_inner_pair();
  endfunction

  function automatic bit take_item(input op_kind_t mode, input longint lo, input longint hi,
                                   input longint fv, output search_out_t r);
    if (mode == OP_START) begin
      left_pt = lo;
      right_pt = hi;
      awaiting = AWAIT_LEFT;
      r = probe_at(1'b0, lo);
      return 1'b1;
    end
    case (awaiting)
      AWAIT_LEFT: begin
        left_val = fv;
        awaiting = AWAIT_RIGHT;
        r = probe_at(1'b0, right_pt);
      end
      AWAIT_RIGHT: begin
        right_val = fv;
        r = place_inner_pair();
      end
      AWAIT_INNER_PAIR: begin
        inl_val = fv;
        awaiting = AWAIT_INNER_RIGHT;
        r = probe_at(1'b0, inr_pt);
      end
      AWAIT_INNER_RIGHT: begin
        inr_val = fv;
        r = narrow_bracket();
      end
      AWAIT_INNER_LEFT: begin
        inl_val = fv;
        r = narrow_bracket();
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic flag(input string what, input string want, input longint seen);
    failures++;
    if (failures <= 10)
      $display("%0t %s: expected %s, got %0d", $time, what, want, seen);
  endtask

  always @(posedge clk) begin : watch
    search_out_t owed, made;
    if (!rst_n) begin
      left_pt = 0;
      inl_pt = 0;
      inr_pt = 0;
      right_pt = 0;
      left_val = 0;
      inl_val = 0;
      inr_val = 0;
      right_val = 0;
      tolerance = TOL_RESET;
      awaiting = AWAIT_NONE;
      owed_q.delete();
      answered = 0;
      failures = 0;
    end else begin
      // the result leaving now was caused by an earlier transfer
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          flag("unexpected result position", "none", out_position);
        end else begin
          owed = owed_q.pop_front();
          if (out_finished !== owed.finished)
            flag("finished", $sformatf("%0d", owed.finished), out_finished);
          if (out_position !== owed.position)
            flag("position", $sformatf("%0d", owed.position), out_position);
        end
      end
      if (cfg_wr_en)
        tolerance = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (take_item(op_kind_t'(in_mode), in_lower_bound, in_upper_bound, in_func_value,
                      made)) begin
          owed_q.push_back(made);
          answered++;
        end
      end
    end
    results_owed <= owed_q.size();
    answered_items <= answered;
    mismatches <= failures;
  end

endmodule

@@ tb/golden_section_minimizer_unit_tb.sv @@
module golden_section_minimizer_unit_tb;
  import gsm_pkg::*;

  localparam logic signed [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] MOST_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam longint WORD_MIN = -(longint'(1) << (WORD_W - 1));
  localparam longint WORD_MAX = (longint'(1) << (WORD_W - 1)) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_SETTING = 210;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [TOL_W-1:0]         cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_mode = 1'b0;
  logic signed [WORD_W-1:0] in_lower_bound = '0;
  logic signed [WORD_W-1:0] in_upper_bound = '0;
  logic signed [WORD_W-1:0] in_func_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_finished;
  logic signed [WORD_W-1:0] out_position;

  int results_owed, answered_items, mismatches;
  bit quiet;
  int holds_asked, holds_served;

  always #5 clk = ~clk;

  golden_section_minimizer_unit dut (.*);

  search_result_checker scoreboard (.*);

  initial begin : time_limit
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly back to back, sometimes a few cycles, now and then a long gap
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : sink
    int gap;
    @(posedge clk);
    forever begin
      if (holds_served < holds_asked) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = quiet ? 0 : idle_length();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic offer(input op_kind_t mode, input logic signed [WORD_W-1:0] lo,
                       input logic signed [WORD_W-1:0] hi,
                       input logic signed [WORD_W-1:0] fv);
    int gap;
    gap = quiet ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_lower_bound <= lo;
    in_upper_bound <= hi;
    in_func_value <= fv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] value);
    drain();
    // ignored replies may still sit inside the block
    repeat (16) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_search();
    longint lo, hi, centre, span;
    int     replies;
    if ($urandom_range(0, 7) == 0) begin
      lo = longint'($signed($urandom));
      hi = longint'($signed($urandom));
    end else begin
      centre = longint'($signed($urandom)) >>> $urandom_range(0, 16);
      span = longint'(1) << $urandom_range(2, 28);
      span = span + (longint'($urandom) & (span - 1));
      lo = centre - span / 2;
      hi = lo + span;
      if (lo < WORD_MIN)
        lo = WORD_MIN;
      if (hi > WORD_MAX)
        hi = WORD_MAX;
      if ($urandom_range(0, 3) == 0)
        {lo, hi} = {hi, lo};
    end
    // a few searches are cut short by the next start
    replies = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 48);
    offer(OP_START, lo[WORD_W-1:0], hi[WORD_W-1:0], $urandom);
    repeat (replies) begin
      if ($urandom_range(0, 1) == 0)
        offer(OP_REPLY, $urandom, $urandom, $urandom_range(0, 3));
      else
        offer(OP_REPLY, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin : stimulus
    int target, searches;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reply with no search running is dropped
    offer(OP_REPLY, MOST_NEG, MOST_POS, MOST_POS);
    offer(OP_START, MOST_NEG, MOST_POS, MOST_NEG);
    offer(OP_REPLY, '0, '0, MOST_POS);
    offer(OP_REPLY, '0, '0, MOST_NEG);
    offer(OP_REPLY, '0, '0, 7);
    offer(OP_REPLY, '0, '0, 7);
    offer(OP_REPLY, '0, '0, 1);
    offer(OP_REPLY, '0, '0, 2);
    offer(OP_REPLY, '0, '0, 3);
    // restart while busy, bounds reversed
    offer(OP_START, 327680, -196608, 0);
    offer(OP_REPLY, MOST_POS, MOST_NEG, -10);
    offer(OP_REPLY, '0, '0, 100);
    offer(OP_REPLY, '0, '0, 0);
    offer(OP_REPLY, '0, '0, 50);
    offer(OP_REPLY, '0, '0, 60);
    offer(OP_REPLY, '0, '0, 20);
    // zero width at the top of the range, width one at the bottom
    offer(OP_START, MOST_POS, MOST_POS, 0);
    repeat (4) offer(OP_REPLY, '0, '0, 0);
    offer(OP_START, MOST_NEG, MOST_NEG + 1, 0);
    repeat (4) offer(OP_REPLY, '0, '0, -1);

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_tolerance(TOL_W'(1));
        2: set_tolerance('1);
        3: set_tolerance(TOL_W'($urandom_range(2, 1 << 20)));
        4: set_tolerance(TOL_RESET);
        default: ;
      endcase
      target = answered_items + ITEMS_PER_SETTING;
      searches = 0;
      while (answered_items < target) begin
        quiet = ($urandom_range(0, 9) == 0);
        // long receiver hold-off while the sender keeps going
        if (searches == 3 && (p == 1 || p == 3)) begin
          quiet = 1'b1;
          holds_asked++;
        end
        if (searches % 6 == 5)
          drain();
        run_search();
        searches++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
